@@ hdl/epqa_pkg.sv @@
// ----------------------------------------------------------------------------
// epqa_pkg
// Shared types, constants and tables of the event-plane q-vector accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package epqa_pkg;

    // CORDIC depth and scaling
    localparam int VEC_ITERS      = 30;
    localparam int ROT_ITERS      = 16;
    localparam int PRESCALE_SHIFT = 10;
    localparam int ROT_W          = 18;
    localparam logic signed [ROT_W-1:0] ROT_START = 18'sd9949;

    // Track cuts
    localparam logic signed [31:0] ION_LIMIT = 32'sd1000000000;
    localparam logic signed [15:0] ETA_SPLIT = 16'sd11469;

    // Result queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Arctangent of 2^-i as 32-bit binary angles
    localparam logic [31:0] ATAN_TAB [0:VEC_ITERS-1] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722,
        32'd20861, 32'd10430, 32'd5215, 32'd2608, 32'd1304,
        32'd652, 32'd326, 32'd163, 32'd81, 32'd41,
        32'd20, 32'd10, 32'd5, 32'd3, 32'd1
    };

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_PT_FLOOR      = 3'd0,
        REG_VTX_R2_MAX    = 3'd1,
        REG_WIN_A_LOW     = 3'd2,
        REG_WIN_A_HIGH    = 3'd3,
        REG_WIN_B_LOW     = 3'd4,
        REG_WIN_B_HIGH    = 3'd5,
        REG_WIN_C_LOW     = 3'd6,
        REG_WIN_C_HIGH    = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic [19:0]        pt_floor;
        logic [47:0]        vertex_radius_sq_max;
        logic signed [15:0] window_a_low;
        logic signed [15:0] window_a_high;
        logic signed [15:0] window_b_low;
        logic signed [15:0] window_b_high;
        logic signed [15:0] window_c_low;
        logic signed [15:0] window_c_high;
    } cfg_t;

    // Classified transaction handed from front to back
    typedef struct packed {
        logic                    eoe;
        logic                    in_a;
        logic                    in_b;
        logic                    in_c;
        logic signed [ROT_W-1:0] a_re;
        logic signed [ROT_W-1:0] a_im;
        logic signed [ROT_W-1:0] bc_re;
        logic signed [ROT_W-1:0] bc_im;
    } qitem_t;

endpackage

`default_nettype wire

@@ hdl/epqa_vec_cordic.sv @@
// ----------------------------------------------------------------------------
// epqa_vec_cordic
// Pipelined vectoring CORDIC: 32-bit binary angle of (x, y), one stage per step.
// ----------------------------------------------------------------------------
`default_nettype none

module epqa_vec_cordic #(
    parameter int IN_W = 21,
    parameter int SB_W = 1
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   en,
    input  wire logic                   in_valid,
    input  wire logic signed [IN_W-1:0] in_x,
    input  wire logic signed [IN_W-1:0] in_y,
    input  wire logic [SB_W-1:0]        in_sb,
    output logic                        out_valid,
    output logic [31:0]                 out_angle,
    output logic [SB_W-1:0]             out_sb
);

    localparam int N = epqa_pkg::VEC_ITERS;
    localparam int W = IN_W + epqa_pkg::PRESCALE_SHIFT + 3;

    logic signed [W-1:0] x_reg [0:N];
    logic signed [W-1:0] y_reg [0:N];
    logic [31:0]         a_reg [0:N];
    logic                zero_reg [0:N];
    logic [SB_W-1:0]     sb_reg [0:N];
    logic                v_reg [0:N];

    logic signed [W-1:0] x_next [0:N];
    logic signed [W-1:0] y_next [0:N];
    logic [31:0]         a_next [0:N];
    logic signed [W-1:0] xsh [0:N-1];
    logic signed [W-1:0] ysh [0:N-1];
    logic signed [W-1:0] xe;
    logic signed [W-1:0] ye;

    // Prescale, fold into the right half plane, then one step per stage
    always_comb
    begin
        xe = {{(W-IN_W-epqa_pkg::PRESCALE_SHIFT){in_x[IN_W-1]}}, in_x,
              {epqa_pkg::PRESCALE_SHIFT{1'b0}}};
        ye = {{(W-IN_W-epqa_pkg::PRESCALE_SHIFT){in_y[IN_W-1]}}, in_y,
              {epqa_pkg::PRESCALE_SHIFT{1'b0}}};
        if (xe < 0)
        begin
            x_next[0] = -xe;
            y_next[0] = -ye;
            a_next[0] = 32'h8000_0000;
        end
        else
        begin
            x_next[0] = xe;
            y_next[0] = ye;
            a_next[0] = 32'h0;
        end
        for (int i = 0; i < N; i++)
        begin
            xsh[i] = x_reg[i] >>> i;
            ysh[i] = y_reg[i] >>> i;
            if (y_reg[i] > 0)
            begin
                x_next[i+1] = x_reg[i] + ysh[i];
                y_next[i+1] = y_reg[i] - xsh[i];
                a_next[i+1] = a_reg[i] + epqa_pkg::ATAN_TAB[i];
            end
            else
            begin
                x_next[i+1] = x_reg[i] - ysh[i];
                y_next[i+1] = y_reg[i] + xsh[i];
                a_next[i+1] = a_reg[i] - epqa_pkg::ATAN_TAB[i];
            end
        end
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= N; i++)
            begin
                v_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
            for (int i = 0; i < N; i++)
            begin
                v_reg[i+1] <= v_reg[i];
            end
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zero_reg[0] <= (in_x == '0) && (in_y == '0);
            sb_reg[0]   <= in_sb;
            for (int i = 0; i <= N; i++)
            begin
                x_reg[i] <= x_next[i];
                y_reg[i] <= y_next[i];
                a_reg[i] <= a_next[i];
            end
            for (int i = 0; i < N; i++)
            begin
                zero_reg[i+1] <= zero_reg[i];
                sb_reg[i+1]   <= sb_reg[i];
            end
        end
    end

    // Zero vector gives angle zero
    assign out_valid = v_reg[N];
    assign out_angle = zero_reg[N] ? 32'h0 : a_reg[N];
    assign out_sb    = sb_reg[N];

endmodule

`default_nettype wire

@@ hdl/epqa_rot_cordic.sv @@
// ----------------------------------------------------------------------------
// epqa_rot_cordic
// Pipelined rotation CORDIC: cos and sin of a 32-bit binary angle, scaled 2^14.
// ----------------------------------------------------------------------------
`default_nettype none

module epqa_rot_cordic #(
    parameter int SB_W = 1
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 en,
    input  wire logic                                 in_valid,
    input  wire logic [31:0]                          in_angle,
    input  wire logic [SB_W-1:0]                      in_sb,
    output logic                                      out_valid,
    output logic signed [epqa_pkg::ROT_W-1:0]         out_cos,
    output logic signed [epqa_pkg::ROT_W-1:0]         out_sin,
    output logic [SB_W-1:0]                           out_sb
);

    localparam int N = epqa_pkg::ROT_ITERS;
    localparam int RW = epqa_pkg::ROT_W;

    logic signed [RW-1:0] x_reg [0:N];
    logic signed [RW-1:0] y_reg [0:N];
    logic signed [32:0]   z_reg [0:N];
    logic                 flip_reg [0:N];
    logic [SB_W-1:0]      sb_reg [0:N];
    logic                 v_reg [0:N];

    logic signed [RW-1:0] x_next [0:N];
    logic signed [RW-1:0] y_next [0:N];
    logic signed [32:0]   z_next [0:N];
    logic signed [RW-1:0] xsh [0:N-1];
    logic signed [RW-1:0] ysh [0:N-1];
    logic signed [32:0]   ze;
    logic                 flip0;

    // Fold the angle into the right half, then one step per stage
    always_comb
    begin
        ze = {in_angle[31], in_angle};
        flip0 = 1'b0;
        z_next[0] = ze;
        if (ze > 33'sd1073741824)
        begin
            z_next[0] = ze - 33'sd2147483648;
            flip0 = 1'b1;
        end
        else if (ze < -33'sd1073741824)
        begin
            z_next[0] = ze + 33'sd2147483648;
            flip0 = 1'b1;
        end
        x_next[0] = epqa_pkg::ROT_START;
        y_next[0] = '0;
        for (int i = 0; i < N; i++)
        begin
            xsh[i] = x_reg[i] >>> i;
            ysh[i] = y_reg[i] >>> i;
            if (z_reg[i] >= 0)
            begin
                x_next[i+1] = x_reg[i] - ysh[i];
                y_next[i+1] = y_reg[i] + xsh[i];
                z_next[i+1] = z_reg[i] - $signed({1'b0, epqa_pkg::ATAN_TAB[i]});
            end
            else
            begin
                x_next[i+1] = x_reg[i] + ysh[i];
                y_next[i+1] = y_reg[i] - xsh[i];
                z_next[i+1] = z_reg[i] + $signed({1'b0, epqa_pkg::ATAN_TAB[i]});
            end
        end
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= N; i++)
            begin
                v_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
            for (int i = 0; i < N; i++)
            begin
                v_reg[i+1] <= v_reg[i];
            end
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            flip_reg[0] <= flip0;
            sb_reg[0]   <= in_sb;
            for (int i = 0; i <= N; i++)
            begin
                x_reg[i] <= x_next[i];
                y_reg[i] <= y_next[i];
                z_reg[i] <= z_next[i];
            end
            for (int i = 0; i < N; i++)
            begin
                flip_reg[i+1] <= flip_reg[i];
                sb_reg[i+1]   <= sb_reg[i];
            end
        end
    end

    // Undo the half-turn fold
    assign out_valid = v_reg[N];
    assign out_cos   = flip_reg[N] ? -x_reg[N] : x_reg[N];
    assign out_sin   = flip_reg[N] ? -y_reg[N] : y_reg[N];
    assign out_sb    = sb_reg[N];

endmodule

`default_nettype wire

@@ hdl/epqa_front.sv @@
// ----------------------------------------------------------------------------
// epqa_front
// Track cuts, window classification, azimuth, sector snap and cos/sin of 2phi.
// ----------------------------------------------------------------------------
`default_nettype none

module epqa_front #(
    parameter int ANGLE_BITS    = 16,
    parameter int OUTER_SECTORS = 8,
    parameter int INNER_SECTORS = 16
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire epqa_pkg::cfg_t      cfg,
    input  wire logic                en,
    input  wire logic                in_valid,
    input  wire logic                req_type,
    input  wire logic [19:0]         pt_mev,
    input  wire logic                is_charged,
    input  wire logic signed [31:0]  species_code,
    input  wire logic signed [23:0]  vertex_x,
    input  wire logic signed [23:0]  vertex_y,
    input  wire logic signed [23:0]  vertex_z,
    input  wire logic signed [15:0]  pseudorapidity,
    input  wire logic signed [20:0]  mom_x,
    input  wire logic signed [20:0]  mom_y,
    output logic                     out_valid,
    output epqa_pkg::qitem_t         out_item
);

    localparam int AB = ANGLE_BITS;
    localparam int TAB_N = 64;
    localparam longint HALF = longint'(1) << (AB - 1);

    // First stage: cuts, squares, windows
    logic               f1_valid_reg;
    logic               f1_eoe_reg;
    logic               f1_cut_reg;
    logic [47:0]        f1_sqx_reg;
    logic [47:0]        f1_sqy_reg;
    logic [47:0]        f1_sqz_reg;
    logic               f1_wa_reg;
    logic               f1_wb_reg;
    logic               f1_wc_reg;
    logic               f1_inner_reg;
    logic signed [20:0] f1_px_reg;
    logic signed [20:0] f1_py_reg;

    logic signed [47:0] sqx;
    logic signed [47:0] sqy;
    logic signed [47:0] sqz;
    logic               cut_ok;

    always_comb
    begin
        sqx = vertex_x * vertex_x;
        sqy = vertex_y * vertex_y;
        sqz = vertex_z * vertex_z;
        cut_ok = (pt_mev >= cfg.pt_floor) && is_charged
            && (species_code <= epqa_pkg::ION_LIMIT)
            && (species_code >= -epqa_pkg::ION_LIMIT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            f1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f1_eoe_reg   <= req_type;
            f1_cut_reg   <= cut_ok;
            f1_sqx_reg   <= sqx;
            f1_sqy_reg   <= sqy;
            f1_sqz_reg   <= sqz;
            f1_wa_reg    <= (pseudorapidity > cfg.window_a_low)
                         && (pseudorapidity < cfg.window_a_high);
            f1_wb_reg    <= (pseudorapidity > cfg.window_b_low)
                         && (pseudorapidity < cfg.window_b_high);
            f1_wc_reg    <= (pseudorapidity > cfg.window_c_low)
                         && (pseudorapidity < cfg.window_c_high);
            f1_inner_reg <= pseudorapidity < epqa_pkg::ETA_SPLIT;
            f1_px_reg    <= mom_x;
            f1_py_reg    <= mom_y;
        end
    end

    // Vertex radius cut; drop rejected tracks before the azimuth unit
    logic [49:0] r2;
    logic        vec_in_valid;

    always_comb
    begin
        r2 = 50'(f1_sqx_reg) + 50'(f1_sqy_reg) + 50'(f1_sqz_reg);
        vec_in_valid = f1_valid_reg
            && (f1_eoe_reg || (f1_cut_reg && (r2 <= 50'(cfg.vertex_radius_sq_max))));
    end

    logic        vec_valid;
    logic [31:0] vec_angle;
    logic [4:0]  vec_sb;

    epqa_vec_cordic #(
        .IN_W (21),
        .SB_W (5)
    ) u_vec (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vec_in_valid),
        .in_x      (f1_px_reg),
        .in_y      (f1_py_reg),
        .in_sb     ({f1_eoe_reg, f1_wa_reg, f1_wb_reg, f1_wc_reg, f1_inner_reg}),
        .out_valid (vec_valid),
        .out_angle (vec_angle),
        .out_sb    (vec_sb)
    );

    // Sector centre tables, offset by minus half a turn
    logic [AB-1:0] inner_tab [0:TAB_N-1];
    logic [AB-1:0] outer_tab [0:TAB_N-1];

    for (genvar k = 0; k < TAB_N; k++)
    begin : g_tab
        localparam longint CU_IN  = ((2 * k + 1) * (longint'(1) << AB)) / (2 * INNER_SECTORS);
        localparam longint CU_OUT = ((2 * k + 1) * (longint'(1) << AB)) / (2 * OUTER_SECTORS);
        assign inner_tab[k] = AB'(CU_IN - HALF);
        assign outer_tab[k] = AB'(CU_OUT - HALF);
    end

    // Round azimuth, snap window A to its sector ring, double both angles
    logic [31:0]   rnd;
    logic [AB-1:0] phi;
    logic [AB-1:0] u;
    logic [AB+6:0] prod_in;
    logic [AB+6:0] prod_out;
    logic [AB-1:0] snap;
    logic [AB-1:0] p2a;
    logic [AB-1:0] p2bc;

    always_comb
    begin
        rnd = vec_angle + (32'd1 << (31 - AB));
        phi = rnd[31 -: AB];
        u = {~phi[AB-1], phi[AB-2:0]};
        prod_in  = (AB+7)'(u) * (AB+7)'(INNER_SECTORS);
        prod_out = (AB+7)'(u) * (AB+7)'(OUTER_SECTORS);
        if (vec_sb[0])
        begin
            snap = (prod_in[AB-1:0] == '0) ? '0 : inner_tab[prod_in[AB+5:AB]];
        end
        else
        begin
            snap = (prod_out[AB-1:0] == '0) ? '0 : outer_tab[prod_out[AB+5:AB]];
        end
        p2a  = {snap[AB-2:0], 1'b0};
        p2bc = {phi[AB-2:0], 1'b0};
    end

    logic              s_valid_reg;
    logic [3:0]        s_sb_reg;
    logic [31:0]       s_ang_a_reg;
    logic [31:0]       s_ang_bc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s_valid_reg <= vec_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_sb_reg     <= vec_sb[4:1];
            s_ang_a_reg  <= {p2a, {(32-AB){1'b0}}};
            s_ang_bc_reg <= {p2bc, {(32-AB){1'b0}}};
        end
    end

    // cos and sin of both doubled angles
    logic                                 rot_valid;
    logic [3:0]                           rot_sb;
    logic signed [epqa_pkg::ROT_W-1:0]    ca;
    logic signed [epqa_pkg::ROT_W-1:0]    sa;
    logic signed [epqa_pkg::ROT_W-1:0]    cbc;
    logic signed [epqa_pkg::ROT_W-1:0]    sbc;

    epqa_rot_cordic #(
        .SB_W (4)
    ) u_rot_a (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_valid_reg),
        .in_angle  (s_ang_a_reg),
        .in_sb     (s_sb_reg),
        .out_valid (rot_valid),
        .out_cos   (ca),
        .out_sin   (sa),
        .out_sb    (rot_sb)
    );

    epqa_rot_cordic #(
        .SB_W (1)
    ) u_rot_bc (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_valid_reg),
        .in_angle  (s_ang_bc_reg),
        .in_sb     (1'b0),
        .out_valid (),
        .out_cos   (cbc),
        .out_sin   (sbc),
        .out_sb    ()
    );

    // Hand the classified transaction to the queue
    always_comb
    begin
        out_valid      = rot_valid;
        out_item.eoe   = rot_sb[3];
        out_item.in_a  = rot_sb[2];
        out_item.in_b  = rot_sb[1];
        out_item.in_c  = rot_sb[0];
        out_item.a_re  = ca;
        out_item.a_im  = sa;
        out_item.bc_re = cbc;
        out_item.bc_im = sbc;
    end

endmodule

`default_nettype wire

@@ hdl/epqa_queue.sv @@
// ----------------------------------------------------------------------------
// epqa_queue
// Small FIFO of classified transactions between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module epqa_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire epqa_pkg::qitem_t  push_item,
    input  wire logic              pop,
    output logic                   full,
    output logic                   not_empty,
    output epqa_pkg::qitem_t       head_item
);

    localparam int D  = epqa_pkg::QUEUE_DEPTH;
    localparam int PW = $clog2(D);

    epqa_pkg::qitem_t mem [0:D-1];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW:0]      count_reg;

    // Store pushed transactions
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    // Move pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(D - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(D - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    assign full      = (count_reg == (PW+1)'(D));
    assign not_empty = (count_reg != '0);
    assign head_item = mem[rd_ptr_reg];

endmodule

`default_nettype wire

@@ hdl/epqa_back.sv @@
// ----------------------------------------------------------------------------
// epqa_back
// Window sums and counts, end-of-event plane angles and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module epqa_back #(
    parameter int COUNT_BITS = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              q_valid,
    input  wire epqa_pkg::qitem_t  q_item,
    output logic                   q_pop,
    input  wire logic              result_stall,
    output logic                   result_valid,
    output logic signed [15:0]     plane_a,
    output logic signed [15:0]     plane_b,
    output logic signed [15:0]     plane_c,
    output logic                   b_present,
    output logic                   c_present
);

    localparam int RW = epqa_pkg::ROT_W;

    function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                   input logic signed [RW-1:0] b);
        logic signed [32:0] r;
        r = 33'(a) + 33'(b);
        if (r > 33'sd2147483647)
        begin
            return 32'sh7FFF_FFFF;
        end
        else if (r < -33'sd2147483648)
        begin
            return 32'sh8000_0000;
        end
        return r[31:0];
    endfunction

    function automatic logic signed [15:0] to_plane(input logic [31:0] ang);
        logic [32:0] u;
        logic [15:0] q;
        u = {1'b0, ~ang[31], ang[30:0]} + 33'd65536;
        q = u[32:17];
        if (q == 16'd0)
        begin
            return 16'sd16384;
        end
        return $signed(q - 16'd16384);
    endfunction

    logic back_en;
    logic result_valid_reg;

    assign back_en = !result_valid_reg || !result_stall;
    assign q_pop   = back_en && q_valid;

    // Accumulate tracks, clear at end of event
    logic signed [31:0]    sum_a_re_reg;
    logic signed [31:0]    sum_a_im_reg;
    logic signed [31:0]    sum_b_re_reg;
    logic signed [31:0]    sum_b_im_reg;
    logic signed [31:0]    sum_c_re_reg;
    logic signed [31:0]    sum_c_im_reg;
    logic [COUNT_BITS-1:0] tracks_a_reg;
    logic [COUNT_BITS-1:0] tracks_b_reg;
    logic [COUNT_BITS-1:0] tracks_c_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_a_re_reg <= '0;
            sum_a_im_reg <= '0;
            sum_b_re_reg <= '0;
            sum_b_im_reg <= '0;
            sum_c_re_reg <= '0;
            sum_c_im_reg <= '0;
            tracks_a_reg <= '0;
            tracks_b_reg <= '0;
            tracks_c_reg <= '0;
        end
        else if (q_pop)
        begin
            if (q_item.eoe)
            begin
                sum_a_re_reg <= '0;
                sum_a_im_reg <= '0;
                sum_b_re_reg <= '0;
                sum_b_im_reg <= '0;
                sum_c_re_reg <= '0;
                sum_c_im_reg <= '0;
                tracks_a_reg <= '0;
                tracks_b_reg <= '0;
                tracks_c_reg <= '0;
            end
            else
            begin
                if (q_item.in_a)
                begin
                    sum_a_re_reg <= sat_add(sum_a_re_reg, q_item.a_re);
                    sum_a_im_reg <= sat_add(sum_a_im_reg, q_item.a_im);
                    if (tracks_a_reg != '1)
                    begin
                        tracks_a_reg <= tracks_a_reg + 1'b1;
                    end
                end
                if (q_item.in_b)
                begin
                    sum_b_re_reg <= sat_add(sum_b_re_reg, q_item.bc_re);
                    sum_b_im_reg <= sat_add(sum_b_im_reg, q_item.bc_im);
                    if (tracks_b_reg != '1)
                    begin
                        tracks_b_reg <= tracks_b_reg + 1'b1;
                    end
                end
                if (q_item.in_c)
                begin
                    sum_c_re_reg <= sat_add(sum_c_re_reg, q_item.bc_re);
                    sum_c_im_reg <= sat_add(sum_c_im_reg, q_item.bc_im);
                    if (tracks_c_reg != '1)
                    begin
                        tracks_c_reg <= tracks_c_reg + 1'b1;
                    end
                end
            end
        end
    end

    // Launch plane angles for an event with window A tracks
    logic        emit;
    logic        va;
    logic [31:0] ang_a;
    logic [31:0] ang_b;
    logic [31:0] ang_c;
    logic        pres_b;
    logic        pres_c;

    assign emit = q_pop && q_item.eoe && (tracks_a_reg != '0);

    epqa_vec_cordic #(
        .IN_W (32),
        .SB_W (1)
    ) u_vec_a (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (back_en),
        .in_valid  (emit),
        .in_x      (sum_a_re_reg),
        .in_y      (sum_a_im_reg),
        .in_sb     (1'b0),
        .out_valid (va),
        .out_angle (ang_a),
        .out_sb    ()
    );

    epqa_vec_cordic #(
        .IN_W (32),
        .SB_W (1)
    ) u_vec_b (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (back_en),
        .in_valid  (emit),
        .in_x      (sum_b_re_reg),
        .in_y      (sum_b_im_reg),
        .in_sb     (tracks_b_reg != '0),
        .out_valid (),
        .out_angle (ang_b),
        .out_sb    (pres_b)
    );

    epqa_vec_cordic #(
        .IN_W (32),
        .SB_W (1)
    ) u_vec_c (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (back_en),
        .in_valid  (emit),
        .in_x      (sum_c_re_reg),
        .in_y      (sum_c_im_reg),
        .in_sb     (tracks_c_reg != '0),
        .out_valid (),
        .out_angle (ang_c),
        .out_sb    (pres_c)
    );

    // Hold the result until taken
    logic signed [15:0] plane_a_reg;
    logic signed [15:0] plane_b_reg;
    logic signed [15:0] plane_c_reg;
    logic               b_present_reg;
    logic               c_present_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (back_en)
        begin
            result_valid_reg <= va;
        end
    end

    always_ff @(posedge clk)
    begin
        if (back_en)
        begin
            plane_a_reg   <= to_plane(ang_a);
            plane_b_reg   <= pres_b ? to_plane(ang_b) : 16'sd0;
            plane_c_reg   <= pres_c ? to_plane(ang_c) : 16'sd0;
            b_present_reg <= pres_b;
            c_present_reg <= pres_c;
        end
    end

    assign result_valid = result_valid_reg;
    assign plane_a      = plane_a_reg;
    assign plane_b      = plane_b_reg;
    assign plane_c      = plane_c_reg;
    assign b_present    = b_present_reg;
    assign c_present    = c_present_reg;

    // End of event leaves the A and B counts and the A real, B imaginary and C real sums cleared
    a_eoe_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && q_item.eoe) |=> (tracks_a_reg == '0 && tracks_b_reg == '0
            && sum_a_re_reg == '0 && sum_b_im_reg == '0 && sum_c_re_reg == '0))
        else $error("sums not cleared after end of event");

    // Minus half turn is always reported as plus half turn
    a_plane_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> (plane_a_reg != -16'sd16384 && plane_b_reg != -16'sd16384
            && plane_c_reg != -16'sd16384))
        else $error("plane at minus half turn");

    // Empty windows report a zero plane
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> ((b_present_reg || plane_b_reg == '0)
            && (c_present_reg || plane_c_reg == '0)))
        else $error("empty window with nonzero plane");

    // Back never pops while the result slot is blocked
    a_no_pop_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_stall) |-> !q_pop)
        else $error("pop while result stalled");

endmodule

`default_nettype wire

@@ hdl/event_plane_qvector_accumulator.sv @@
// ----------------------------------------------------------------------------
// event_plane_qvector_accumulator
// Three-window second-harmonic q-vector accumulator with event-plane output.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle while the queue is not full (item_stall low),
// set by the fully pipelined CORDIC units. Path of an end-of-event marker:
// front (cuts, 31-stage azimuth, snap, 17-stage cos/sin), the queue, then back
// (31-stage plane angle, result register).
// Reset: configuration returns to its defaults, sums and counts clear, all
// pipelines and the queue empty; no clearing pass is needed.
`default_nettype none

module event_plane_qvector_accumulator #(
    parameter int ANGLE_BITS    = 16,
    parameter int OUTER_SECTORS = 8,
    parameter int INNER_SECTORS = 16,
    parameter int COUNT_BITS    = 16
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [2:0]          cfg_index,
    input  wire logic [47:0]         cfg_data,
    input  wire logic                item_valid,
    output logic                     item_stall,
    input  wire logic                req_type,
    input  wire logic [19:0]         pt_mev,
    input  wire logic                is_charged,
    input  wire logic signed [31:0]  species_code,
    input  wire logic signed [23:0]  vertex_x,
    input  wire logic signed [23:0]  vertex_y,
    input  wire logic signed [23:0]  vertex_z,
    input  wire logic signed [15:0]  pseudorapidity,
    input  wire logic signed [20:0]  mom_x,
    input  wire logic signed [20:0]  mom_y,
    output logic                     result_valid,
    input  wire logic                result_stall,
    output logic signed [15:0]       plane_a,
    output logic signed [15:0]       plane_b,
    output logic signed [15:0]       plane_c,
    output logic                     b_present,
    output logic                     c_present
);

    // Configuration registers
    epqa_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pt_floor             <= 20'd200;
            cfg_reg.vertex_radius_sq_max <= 48'd25000000;
            cfg_reg.window_a_low         <= 16'sd9011;
            cfg_reg.window_a_high        <= 16'sd20480;
            cfg_reg.window_b_low         <= -16'sd3277;
            cfg_reg.window_b_high        <= -16'sd410;
            cfg_reg.window_c_low         <= 16'sd410;
            cfg_reg.window_c_high        <= 16'sd3277;
        end
        else if (cfg_valid)
        begin
            unique case (epqa_pkg::cfg_reg_t'(cfg_index))
                epqa_pkg::REG_PT_FLOOR:   cfg_reg.pt_floor <= cfg_data[19:0];
                epqa_pkg::REG_VTX_R2_MAX: cfg_reg.vertex_radius_sq_max <= cfg_data;
                epqa_pkg::REG_WIN_A_LOW:  cfg_reg.window_a_low <= cfg_data[15:0];
                epqa_pkg::REG_WIN_A_HIGH: cfg_reg.window_a_high <= cfg_data[15:0];
                epqa_pkg::REG_WIN_B_LOW:  cfg_reg.window_b_low <= cfg_data[15:0];
                epqa_pkg::REG_WIN_B_HIGH: cfg_reg.window_b_high <= cfg_data[15:0];
                epqa_pkg::REG_WIN_C_LOW:  cfg_reg.window_c_low <= cfg_data[15:0];
                epqa_pkg::REG_WIN_C_HIGH: cfg_reg.window_c_high <= cfg_data[15:0];
                default:                  cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Front freezes while the queue is full
    logic              q_full;
    logic              q_not_empty;
    logic              q_pop;
    logic              front_valid;
    epqa_pkg::qitem_t  front_item;
    epqa_pkg::qitem_t  head_item;

    assign item_stall = q_full;

    epqa_front #(
        .ANGLE_BITS    (ANGLE_BITS),
        .OUTER_SECTORS (OUTER_SECTORS),
        .INNER_SECTORS (INNER_SECTORS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .en             (!q_full),
        .in_valid       (item_valid),
        .req_type       (req_type),
        .pt_mev         (pt_mev),
        .is_charged     (is_charged),
        .species_code   (species_code),
        .vertex_x       (vertex_x),
        .vertex_y       (vertex_y),
        .vertex_z       (vertex_z),
        .pseudorapidity (pseudorapidity),
        .mom_x          (mom_x),
        .mom_y          (mom_y),
        .out_valid      (front_valid),
        .out_item       (front_item)
    );

    epqa_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (front_valid && !q_full),
        .push_item (front_item),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head_item (head_item)
    );

    epqa_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_not_empty),
        .q_item       (head_item),
        .q_pop        (q_pop),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .plane_a      (plane_a),
        .plane_b      (plane_b),
        .plane_c      (plane_c),
        .b_present    (b_present),
        .c_present    (c_present)
    );

endmodule

`default_nettype wire
